[sv/blist_pkg.sv]
package blist_pkg;

  localparam int DEPTH = 16;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;
  localparam int ENTRY_W = 5;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef struct packed {
    logic             do_insert;
    logic             do_remove;
    logic [VAL_W-1:0] value;
  } cell_ctrl_t;

endpackage

[sv/blist_in_if.sv]
interface blist_in_if;
  logic                                valid;
  logic                                ready;
  blist_pkg::op_t                      op;
  logic signed [blist_pkg::VAL_W-1:0]  item_value;

  modport source (output valid, output op, output item_value, input ready);
  modport sink (input valid, input op, input item_value, output ready);
endinterface

[sv/blist_out_if.sv]
interface blist_out_if;
  logic                            valid;
  logic                            ready;
  logic                            hit;
  logic                            stored;
  logic                            is_full;
  logic [blist_pkg::ENTRY_W-1:0]   entry_count;

  modport source (output valid, output hit, output stored, output is_full,
                  output entry_count, input ready);
  modport sink (input valid, input hit, input stored, input is_full,
                input entry_count, output ready);
endinterface

[sv/blist_cell.sv]
module blist_cell (
  input  logic                          clk,
  input  blist_pkg::cell_ctrl_t         ctrl,
  input  logic                          occupied,
  input  logic                          ins_here,
  input  logic                          found_in,
  input  logic [blist_pkg::VAL_W-1:0]   right_value,
  output logic                          found_out,
  output logic [blist_pkg::VAL_W-1:0]   value
);

  logic match;

  assign match = occupied && (value == ctrl.value);
  assign found_out = found_in | match;

  always_ff @(posedge clk) begin
    if (ctrl.do_insert && ins_here) begin
      value <= ctrl.value;
    end else if (ctrl.do_remove && found_out) begin
      value <= right_value;
    end
  end

endmodule

[sv/bounded_list_insert_search_remove.sv]
// channel   dir  handshake            payload
// in_ch     in   valid/ready          op, item_value
// out_ch    out  valid/ready          hit, stored, is_full, entry_count
// cfg       in   cfg_we (no ready)    cfg_wdata = list_capacity
//
// One item per cycle: the cell row compares all entries and shifts in the
// accept cycle, and the result is captured in the output register.
// A new item is taken while the output register is empty or being drained.
// Reset (rst, synchronous) empties the list and sets capacity to 16;
// entry storage is not cleared. A stalled output holds in_ch.ready low.
module bounded_list_insert_search_remove (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [blist_pkg::CAP_W-1:0]     cfg_wdata,
  blist_in_if.sink                        in_ch,
  blist_out_if.source                     out_ch
);

  logic [blist_pkg::CAP_W-1:0] capacity;
  logic [blist_pkg::CNT_W-1:0] count;
  logic [blist_pkg::CNT_W-1:0] count_next;
  logic [blist_pkg::CMP_W-1:0] eff_cap;
  logic [blist_pkg::CMP_W-1:0] count_ext;
  logic [blist_pkg::CMP_W-1:0] count_next_ext;
  logic                        accept;
  logic                        room;
  logic                        hit_now;
  logic                        stored_now;
  blist_pkg::cell_ctrl_t       ctrl;
  logic [blist_pkg::DEPTH:0]   found;
  logic [blist_pkg::VAL_W-1:0] values [blist_pkg::DEPTH];

  assign in_ch.ready = !rst && (!out_ch.valid || out_ch.ready);
  assign accept = in_ch.valid && in_ch.ready;

  assign eff_cap = (blist_pkg::CMP_W'(capacity) > blist_pkg::CMP_W'(blist_pkg::DEPTH)) ?
                   blist_pkg::CMP_W'(blist_pkg::DEPTH) : blist_pkg::CMP_W'(capacity);
  assign count_ext = blist_pkg::CMP_W'(count);
  assign room = count_ext < eff_cap;

  assign ctrl.do_insert = accept && (in_ch.op == blist_pkg::OP_INSERT) && room;
  assign ctrl.do_remove = accept && (in_ch.op == blist_pkg::OP_REMOVE);
  assign ctrl.value = in_ch.item_value;

  assign found[0] = 1'b0;

  for (genvar i = 0; i < blist_pkg::DEPTH; i++) begin : g_cell
    logic [blist_pkg::VAL_W-1:0] right;
    if (i == blist_pkg::DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid
      assign right = values[i+1];
    end
    blist_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (blist_pkg::CNT_W'(i) < count),
      .ins_here    (blist_pkg::CNT_W'(i) == count),
      .found_in    (found[i]),
      .right_value (right),
      .found_out   (found[i+1]),
      .value       (values[i])
    );
  end

  always_comb begin
    hit_now = 1'b0;
    stored_now = 1'b0;
    count_next = count;
    case (in_ch.op)
      blist_pkg::OP_INSERT: begin
        stored_now = room;
        if (room) begin
          count_next = count + 1'b1;
        end
      end
      blist_pkg::OP_SEARCH: begin
        hit_now = found[blist_pkg::DEPTH];
      end
      blist_pkg::OP_REMOVE: begin
        hit_now = found[blist_pkg::DEPTH];
        if (found[blist_pkg::DEPTH]) begin
          count_next = count - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign count_next_ext = blist_pkg::CMP_W'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= blist_pkg::CAP_RESET;
      count <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (accept) begin
        count <= count_next;
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ch.hit <= hit_now;
      out_ch.stored <= stored_now;
      out_ch.is_full <= count_next_ext >= eff_cap;
      out_ch.entry_count <= count_next_ext[blist_pkg::ENTRY_W-1:0];
    end
  end

`ifndef SYNTH
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ctrl.do_insert |=> count == blist_pkg::CNT_W'($past(count) + 1'b1))
    else $error("insert did not grow the list");

  a_miss_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_ch.op == blist_pkg::OP_REMOVE) && !found[blist_pkg::DEPTH])
    |=> $stable(count))
    else $error("remove without match changed the count");

  a_result_count: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.entry_count == blist_pkg::ENTRY_W'(count))
    else $error("reported count disagrees with held count");

  a_never_overfull: assert property (@(posedge clk) disable iff (rst)
    blist_pkg::CMP_W'(count) <= blist_pkg::CMP_W'(blist_pkg::DEPTH))
    else $error("count above depth");
`endif

endmodule
